FILE: hdl/gpr_pkg.sv
// Package for the gamepad report builder: beat payload types, field widths,
// hat codes and register map. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gpr_pkg;

   localparam int FretW    = 5;
   localparam int StrumW   = 2;
   localparam int CtrlW    = 3;
   localparam int DirW     = 3;
   localparam int SideW    = 2;
   localparam int SampleW  = 12;
   localparam int TimeW    = 32;
   localparam int HoldW    = 16;
   localparam int MaskW    = 10;
   localparam int HatW     = 4;
   localparam int AxisW    = 8;

   // APB map: one 32-bit register, word index taken from paddr[2]
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;
   localparam logic CSR_IDX_TILT_HOLD = 1'b0;

   localparam logic [HoldW-1:0] TILT_HOLD_RESET = 16'd50;

   localparam logic signed [AxisW-1:0] TILT_AXIS_ACTIVE = -8'sd127;
   localparam logic signed [AxisW-1:0] TILT_AXIS_IDLE   = 8'sd0;

   localparam logic [HatW-1:0] HAT_N      = 4'd0;
   localparam logic [HatW-1:0] HAT_NE     = 4'd1;
   localparam logic [HatW-1:0] HAT_E      = 4'd2;
   localparam logic [HatW-1:0] HAT_SE     = 4'd3;
   localparam logic [HatW-1:0] HAT_S      = 4'd4;
   localparam logic [HatW-1:0] HAT_SW     = 4'd5;
   localparam logic [HatW-1:0] HAT_W      = 4'd6;
   localparam logic [HatW-1:0] HAT_NW     = 4'd7;
   localparam logic [HatW-1:0] HAT_CENTRE = 4'd8;

   typedef struct packed {
      logic [FretW-1:0]   fret_levels_n;
      logic [StrumW-1:0]  strum_levels_n;
      logic [CtrlW-1:0]   control_levels_n;
      logic               tilt_level_n;
      logic [DirW-1:0]    up_levels_n;
      logic [DirW-1:0]    down_levels_n;
      logic [SideW-1:0]   side_levels_n;
      logic [SampleW-1:0] whammy_sample;
      logic [TimeW-1:0]   now_ms;
   } req_payload_type;

   // stateless part of the report
   typedef struct packed {
      logic [MaskW-1:0]   button_mask;
      logic [HatW-1:0]    hat_code;
      logic [AxisW-1:0]   whammy_axis;
   } report_fields_type;

   // debounce control from the pipeline to the tilt unit
   typedef struct packed {
      logic               update;
      logic               raw_active;
      logic [TimeW-1:0]   now_ms;
   } tilt_ctrl_type;

endpackage

`default_nettype wire

FILE: hdl/gpr_channels.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on gpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gpr_req_if import gpr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FretW-1:0]   fret_levels_n;
   logic [StrumW-1:0]  strum_levels_n;
   logic [CtrlW-1:0]   control_levels_n;
   logic               tilt_level_n;
   logic [DirW-1:0]    up_levels_n;
   logic [DirW-1:0]    down_levels_n;
   logic [SideW-1:0]   side_levels_n;
   logic [SampleW-1:0] whammy_sample;
   logic [TimeW-1:0]   now_ms;

   modport source (
      output valid, fret_levels_n, strum_levels_n, control_levels_n, tilt_level_n,
             up_levels_n, down_levels_n, side_levels_n, whammy_sample, now_ms,
      input  ready
   );
   modport sink (
      input  valid, fret_levels_n, strum_levels_n, control_levels_n, tilt_level_n,
             up_levels_n, down_levels_n, side_levels_n, whammy_sample, now_ms,
      output ready
   );
endinterface

interface gpr_rsp_if import gpr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [MaskW-1:0]        button_mask;
   logic [HatW-1:0]         hat_code;
   logic [AxisW-1:0]        whammy_axis;
   logic signed [AxisW-1:0] tilt_axis;
   logic                    tilt_engaged;

   modport source (
      output valid, button_mask, hat_code, whammy_axis, tilt_axis, tilt_engaged,
      input  ready
   );
   modport sink (
      input  valid, button_mask, hat_code, whammy_axis, tilt_axis, tilt_engaged,
      output ready
   );
endinterface

`default_nettype wire

FILE: hdl/gpr_csr.sv
// APB register block holding the tilt hold time.
// Depends on gpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpr_csr import gpr_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [CsrAddrW-1:0] paddr,
   input  wire logic [CsrDataW-1:0] pwdata,
   output logic      [CsrDataW-1:0] prdata,
   output logic                     pready,
   output logic      [HoldW-1:0]    hold_ms
);

   logic [HoldW-1:0] hold_ff;
   logic [HoldW-1:0] hold_in;
   logic             hit;

   assign hit = (paddr[2] == CSR_IDX_TILT_HOLD);

   always_comb begin
      hold_in = hold_ff;
      if (psel && penable && pwrite && hit) begin
         hold_in = pwdata[HoldW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= TILT_HOLD_RESET;
      end else begin
         hold_ff <= hold_in;
      end
   end

   assign prdata  = hit ? {{(CsrDataW-HoldW){1'b0}}, hold_ff} : '0;
   assign pready  = 1'b1;
   assign hold_ms = hold_ff;

endmodule

`default_nettype wire

FILE: hdl/gpr_tilt.sv
// Tilt switch debounce: stable level plus time of last disagreement.
// Depends on gpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpr_tilt import gpr_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tilt_ctrl_type    ctrl,
   input  wire logic [HoldW-1:0] hold_ms,
   output logic                  stable_next
);

   logic             stable_ff;
   logic             stable_in;
   logic [TimeW-1:0] last_ff;
   logic [TimeW-1:0] last_in;
   logic [TimeW-1:0] elapsed;
   logic             mismatch;

   assign mismatch = ctrl.update && (ctrl.raw_active != stable_ff);
   // wraps modulo 2^32
   assign elapsed  = ctrl.now_ms - last_ff;

   always_comb begin
      stable_in = stable_ff;
      last_in   = last_ff;
      if (mismatch) begin
         last_in = ctrl.now_ms;
         if (elapsed > {{(TimeW-HoldW){1'b0}}, hold_ms}) begin
            stable_in = ctrl.raw_active;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         last_ff   <= '0;
      end else begin
         stable_ff <= stable_in;
         last_ff   <= last_in;
      end
   end

   assign stable_next = stable_in;

endmodule

`default_nettype wire

FILE: hdl/gpr_encode.sv
// Button mask, hat code and whammy scaling; pure combinational.
// Depends on gpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpr_encode import gpr_pkg::*; (
   input  wire req_payload_type req,
   output report_fields_type    report
);

   logic                 up, down, left, right;
   logic [HatW-1:0]      hat;
   logic [SampleW+7:0]   scaled;   // sample * 255
   logic [SampleW+7:0]   folded;

   assign up    = (req.up_levels_n != '1);
   assign down  = (req.down_levels_n != '1);
   assign left  = !req.side_levels_n[0];
   assign right = !req.side_levels_n[1];

   always_comb begin
      if (up) begin
         hat = left ? HAT_NW : (right ? HAT_NE : HAT_N);
      end else if (down) begin
         hat = left ? HAT_SW : (right ? HAT_SE : HAT_S);
      end else if (left) begin
         hat = HAT_W;
      end else if (right) begin
         hat = HAT_E;
      end else begin
         hat = HAT_CENTRE;
      end
   end

   assign report.hat_code = hat;

   assign report.button_mask = {~req.control_levels_n, ~req.strum_levels_n,
                                ~req.fret_levels_n};

   // y / 4095 == (y + (y >> 12) + 1) >> 12, exact for y below 2^24 - 1
   assign scaled = {req.whammy_sample, 8'd0} - {8'd0, req.whammy_sample};
   assign folded = scaled + (scaled >> SampleW) + {{(SampleW+7){1'b0}}, 1'b1};
   assign report.whammy_axis = folded[SampleW+7:SampleW];

endmodule

`default_nettype wire

FILE: hdl/gamepad_report_builder_top.sv
// An accepted request beat is held in stage 1, then moves into the result register that drives rsp.
// Throughput: one beat per cycle, set by the input register and the result register;
// the two stages stall together only when the result register is full and not taken.
// Reset (synchronous, active high): pipeline emptied, tilt hold back to 50 ms,
// debounced tilt inactive, last disagreement time zero.
// Depends on gpr_pkg, gpr_channels, gpr_csr, gpr_tilt, gpr_encode.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_report_builder_top import gpr_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   gpr_req_if.sink                  req,
   gpr_rsp_if.source                rsp,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [CsrDataW-1:0] csr_pwdata,
   output logic      [CsrDataW-1:0] csr_prdata,
   output logic                     csr_pready
);

   // --- pipeline control ---
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_ff, s1_in;
   logic            out_valid_ff, out_valid_in;
   logic            accept;     // request beat taken
   logic            advance;    // stage 1 moves into the result register

   // result register
   report_fields_type         report_ff;
   logic                      tilt_ff;
   report_fields_type         report_in;

   logic [HoldW-1:0]          hold_ms;
   tilt_ctrl_type             tilt_ctrl;
   logic                      tilt_next;

   // Stage 1 may move on when the result register is empty or being drained.
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   assign s1_in = '{
      fret_levels_n:    req.fret_levels_n,
      strum_levels_n:   req.strum_levels_n,
      control_levels_n: req.control_levels_n,
      tilt_level_n:     req.tilt_level_n,
      up_levels_n:      req.up_levels_n,
      down_levels_n:    req.down_levels_n,
      side_levels_n:    req.side_levels_n,
      whammy_sample:    req.whammy_sample,
      now_ms:           req.now_ms
   };

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (advance) begin
         report_ff <= report_in;
         tilt_ff   <= tilt_next;
      end
   end

   // --- config registers ---
   gpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .hold_ms (hold_ms)
   );

   // --- debounce: state moves once per beat, in acceptance order ---
   assign tilt_ctrl = '{
      update:     advance,
      raw_active: !s1_ff.tilt_level_n,
      now_ms:     s1_ff.now_ms
   };

   gpr_tilt u_tilt (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (tilt_ctrl),
      .hold_ms     (hold_ms),
      .stable_next (tilt_next)
   );

   // --- stateless fields ---
   gpr_encode u_encode (
      .req    (s1_ff),
      .report (report_in)
   );

   // --- response beat ---
   assign rsp.valid        = out_valid_ff;
   assign rsp.button_mask  = report_ff.button_mask;
   assign rsp.hat_code     = report_ff.hat_code;
   assign rsp.whammy_axis  = report_ff.whammy_axis;
   assign rsp.tilt_engaged = tilt_ff;
   assign rsp.tilt_axis    = tilt_ff ? TILT_AXIS_ACTIVE : TILT_AXIS_IDLE;

`ifndef SYNTHESIS
   // a held stage-1 beat must not vanish
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("stage 1 beat dropped while stalled");

   // a beat moved into the result register shows up next cycle
   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register not filled after advance");

   // a stalled result is not overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp.ready |-> !advance)
      else $error("result overwritten while stalled");

   // hat code stays within the nine defined codes
   a_hat_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (report_ff.hat_code <= HAT_CENTRE))
      else $error("hat code out of range");
`endif

endmodule

`default_nettype wire
